// ===== sv/keyboard_scancode_assembler_unit_assert.svh =====
// Assertion macros shared by the scancode assembler RTL.
// Active in simulation; empty when SYNTH is defined.
`ifndef KEYBOARD_SCANCODE_ASSEMBLER_UNIT_ASSERT_SVH
`define KEYBOARD_SCANCODE_ASSEMBLER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define KSA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scancode assembler check failed");
// Next-cycle implication, disabled during reset
`define KSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scancode assembler check failed");
`else
`define KSA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define KSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ksa_pkg.sv =====
// Package for the keyboard scancode assembler: sizes, byte codes, event type.
// No dependencies.
package ksa_pkg;

    // Group buffer depth; the index wraps to zero at this value
    localparam int SEQUENCE_DEPTH = 7;
    localparam int SEQ_IDX_W      = $clog2(SEQUENCE_DEPTH);
    // Only the first six positions are ever looked at
    localparam int SEQ_READ_DEPTH = 6;

    // Byte codes
    localparam logic [7:0] BYTE_NULL     = 8'h00;
    localparam logic [7:0] BYTE_ACK      = 8'hFA;
    localparam logic [7:0] BYTE_RESEND   = 8'hFE;
    localparam logic [7:0] BYTE_ERROR    = 8'hFF;
    localparam logic [7:0] PFX_EXT1      = 8'hE0;
    localparam logic [7:0] PFX_EXT2      = 8'hE1;
    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [7:0] PAUSE_MAKE1   = 8'h1D;
    localparam logic [7:0] PAUSE_MAKE2   = 8'h45;
    localparam logic [7:0] PAUSE_BREAK1  = 8'h9D;
    localparam logic [7:0] PAUSE_BREAK2  = 8'hC5;

    // Prefix kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_E0   = 2'd1;
    localparam logic [1:0] KIND_E1   = 2'd2;

    typedef logic [SEQ_IDX_W-1:0] seq_idx_t;

    // One assembled key event plus its valid flag
    typedef struct packed {
        logic       valid;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] kind;
    } ksa_event_t;

endpackage

// ===== sv/keyboard_scancode_assembler_unit.sv =====
// A byte waits in the input register until the result register is free.
// Throughput: one byte per cycle while out_stall holds no result; the decode is
// a single pass between the input and result registers, and the index updates in that pass.
// Reset (rst_n low, asynchronous) empties both registers and clears the index.
// Top level of the keyboard scancode assembler; depends on ksa_pkg, ksa_group
// and keyboard_scancode_assembler_unit_assert.svh.
`include "keyboard_scancode_assembler_unit_assert.svh"
module keyboard_scancode_assembler_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       batch_start,
    input  logic       from_mouse,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [7:0] third_byte,
    output logic [1:0] prefix_kind
);
    import ksa_pkg::*;

    logic       s1_valid_reg;
    logic       s1_batch_reg;
    logic       s1_mouse_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;
    logic [1:0] kind_reg;

    logic       out_free;
    logic       s1_adv;
    logic       in_accept;
    ksa_event_t evt;

    // Handshake: input stage moves on whenever the result slot is free
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    ksa_group u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .batch_start (s1_batch_reg),
        .from_mouse  (s1_mouse_reg),
        .data_byte   (s1_byte_reg),
        .evt         (evt)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= evt.valid;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_batch_reg <= batch_start;
            s1_mouse_reg <= from_mouse;
            s1_byte_reg  <= data_byte;
        end
        if (s1_adv && evt.valid)
        begin
            b0_reg   <= evt.b0;
            b1_reg   <= evt.b1;
            b2_reg   <= evt.b2;
            kind_reg <= evt.kind;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_byte  = b0_reg;
    assign second_byte = b1_reg;
    assign third_byte  = b2_reg;
    assign prefix_kind = kind_reg;

    // Checks
    `KSA_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `KSA_ASSERT_IMPLIES(a_kind_range, clk, rst_n, out_valid_reg, kind_reg != 2'd3)
    `KSA_ASSERT_IMPLIES(a_plain_zero, clk, rst_n, out_valid_reg && kind_reg == KIND_NONE, b1_reg == 8'h00 && b2_reg == 8'h00)
    `KSA_ASSERT_IMPLIES(a_e0_head, clk, rst_n, out_valid_reg && kind_reg == KIND_E0, b0_reg == PFX_EXT1)

endmodule

// ===== sv/ksa_group.sv =====
// Grouping core: holds the byte group and its index, decodes one byte per step.
// Depends on ksa_pkg.
module ksa_group (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                batch_start,
    input  logic                from_mouse,
    input  logic [7:0]          data_byte,
    output ksa_pkg::ksa_event_t evt
);
    import ksa_pkg::*;

    logic [7:0] seq_reg [SEQ_READ_DEPTH];
    seq_idx_t   idx_reg;
    seq_idx_t   idx_next;

    seq_idx_t           idx_eff;
    logic               drop;
    logic               done;
    logic [7:0]         cur [SEQ_READ_DEPTH];
    logic [7:0]         head;
    logic [SEQ_IDX_W:0] idx_inc;

    // Effective index and bytes that restart grouping
    always_comb
    begin
        idx_eff = batch_start ? '0 : idx_reg;
        if ({1'b0, idx_eff} >= (SEQ_IDX_W+1)'(SEQUENCE_DEPTH))
        begin
            idx_eff = '0;
        end
        drop = from_mouse || (data_byte == BYTE_NULL) || (data_byte == BYTE_ACK) ||
               (data_byte == BYTE_RESEND) || (data_byte == BYTE_ERROR);
    end

    // Group contents with the new byte merged in
    always_comb
    begin
        for (int k = 0; k < SEQ_READ_DEPTH; k++)
        begin
            cur[k] = (idx_eff == SEQ_IDX_W'(k)) ? data_byte : seq_reg[k];
        end
        head = cur[0];
    end

    // Event decode and next index
    always_comb
    begin
        evt  = '0;
        done = 1'b0;
        if (head == PFX_EXT1)
        begin
            if (idx_eff == SEQ_IDX_W'(1))
            begin
                if (cur[1] != CODE_BREAK)
                begin
                    evt  = '{valid: 1'b1, b0: head, b1: cur[1], b2: 8'h00, kind: KIND_E0};
                    done = 1'b1;
                end
            end
            else if (idx_eff == SEQ_IDX_W'(2))
            begin
                if (cur[1] == CODE_BREAK)
                begin
                    evt = '{valid: 1'b1, b0: head, b1: cur[1], b2: cur[2], kind: KIND_E0};
                end
                done = 1'b1;
            end
        end
        else if (head == PFX_EXT2)
        begin
            if (idx_eff == SEQ_IDX_W'(2))
            begin
                evt = '{valid: 1'b1, b0: head, b1: cur[1], b2: cur[2], kind: KIND_E1};
                done = (cur[2] != PAUSE_MAKE2);
            end
            else if (idx_eff == SEQ_IDX_W'(5))
            begin
                // Pause release tail ends on C5, matching or not
                if (cur[5] == PAUSE_BREAK2)
                begin
                    if (cur[3] == PFX_EXT2 && cur[4] == PAUSE_BREAK1)
                    begin
                        evt = '{valid: 1'b1, b0: cur[3], b1: cur[4], b2: cur[5],
                                kind: KIND_E1};
                    end
                    done = 1'b1;
                end
            end
        end
        else
        begin
            if (idx_eff == '0)
            begin
                evt = '{valid: 1'b1, b0: head, b1: 8'h00, b2: 8'h00, kind: KIND_NONE};
            end
            done = 1'b1;
        end

        idx_inc = {1'b0, idx_eff} + (SEQ_IDX_W+1)'(1);
        if (done || idx_inc >= (SEQ_IDX_W+1)'(SEQUENCE_DEPTH))
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_inc[SEQ_IDX_W-1:0];
        end

        // Ignored bytes give nothing and restart grouping
        if (drop)
        begin
            evt      = '0;
            idx_next = '0;
        end
    end

    // Sequence index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (step)
        begin
            idx_reg <= idx_next;
        end
    end

    // Group bytes; undefined until written
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SEQ_READ_DEPTH; k++)
        begin
            if (step && !drop && idx_eff == SEQ_IDX_W'(k))
            begin
                seq_reg[k] <= data_byte;
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for keyboard_scancode_assembler_unit: predicts key events from
// the accepted bytes and checks every result in order. Depends on ksa_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksa_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    // Bytes the block throws away and uses to restart grouping
    function automatic bit is_dropped(input logic [7:0] b);
        return b == BYTE_NULL || b == BYTE_ACK || b == BYTE_RESEND || b == BYTE_ERROR;
    endfunction

    // Tracks the grouping state and the key events still owed by the block
    class key_event_predictor;
        logic [7:0]  grp_bytes [SEQUENCE_DEPTH];
        int unsigned grp_pos;
        ksa_event_t  pending_events [$];
        int unsigned mismatches;

        function new();
            foreach (grp_bytes[i])
                grp_bytes[i] = 8'h00;
            grp_pos    = 0;
            mismatches = 0;
        endfunction

        function void queue_event(input logic [7:0] b0, b1, b2, input logic [1:0] kind);
            ksa_event_t ev;
            ev.valid = 1'b1;
            ev.b0    = b0;
            ev.b1    = b1;
            ev.b2    = b2;
            ev.kind  = kind;
            pending_events.push_back(ev);
        endfunction

        // One accepted byte: update the group and queue any event it completes
        function void note_byte(input logic bs, input logic mouse, input logic [7:0] b);
            int unsigned pos;
            logic [7:0]  head;
            bit          ends;
            if (bs)
                grp_pos = 0;
            if (mouse || is_dropped(b))
            begin
                grp_pos = 0;
                return;
            end
            pos = (grp_pos >= SEQUENCE_DEPTH) ? 0 : grp_pos;
            grp_bytes[pos] = b;
            head = grp_bytes[0];
            ends = 1'b0;
            case (head)
                PFX_EXT1:
                begin
                    if (pos == 1)
                    begin
                        if (grp_bytes[1] != CODE_BREAK)
                        begin
                            queue_event(head, grp_bytes[1], 8'h00, KIND_E0);
                            ends = 1'b1;
                        end
                    end
                    else if (pos == 2)
                    begin
                        if (grp_bytes[1] == CODE_BREAK)
                            queue_event(head, grp_bytes[1], grp_bytes[2], KIND_E0);
                        ends = 1'b1;
                    end
                end
                PFX_EXT2:
                begin
                    if (pos == 2)
                    begin
                        queue_event(head, grp_bytes[1], grp_bytes[2], KIND_E1);
                        // pause make keeps the group open for the release tail
                        if (grp_bytes[2] != PAUSE_MAKE2)
                            ends = 1'b1;
                    end
                    else if (pos == 5 && grp_bytes[5] == PAUSE_BREAK2)
                    begin
                        if (grp_bytes[3] == PFX_EXT2 && grp_bytes[4] == PAUSE_BREAK1)
                            queue_event(grp_bytes[3], grp_bytes[4], grp_bytes[5], KIND_E1);
                        ends = 1'b1;
                    end
                end
                default:
                begin
                    if (pos == 0)
                        queue_event(head, 8'h00, 8'h00, KIND_NONE);
                    ends = 1'b1;
                end
            endcase
            pos++;
            if (pos >= SEQUENCE_DEPTH || ends)
                pos = 0;
            grp_pos = pos;
        endfunction

        task report_mismatch(input string what);
            $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // One accepted result against the oldest owed event
        task check_event(input logic [7:0] b0, b1, b2, input logic [1:0] kind);
            ksa_event_t ev;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event %h %h %h kind %0d",
                                          b0, b1, b2, kind));
                return;
            end
            ev = pending_events.pop_front();
            if (b0 !== ev.b0)
                report_mismatch($sformatf("first_byte %h, want %h", b0, ev.b0));
            if (b1 !== ev.b1)
                report_mismatch($sformatf("second_byte %h, want %h", b1, ev.b1));
            if (b2 !== ev.b2)
                report_mismatch($sformatf("third_byte %h, want %h", b2, ev.b2));
            if (kind !== ev.kind)
                report_mismatch($sformatf("prefix_kind %0d, want %0d", kind, ev.kind));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       batch_start;
    logic       from_mouse;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [1:0] prefix_kind;

    key_event_predictor predictor = new();
    int  items_sent  = 0;
    int  cycle_count = 0;
    bit  tx_idle     = 1'b0;
    bit  rx_idle     = 1'b0;
    logic hold_off;

    keyboard_scancode_assembler_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .batch_start (batch_start),
        .from_mouse  (from_mouse),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .prefix_kind (prefix_kind)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Any byte the block keeps
    function automatic logic [7:0] pick_code();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_dropped(b));
        return b;
    endfunction

    // A byte that stands alone as a key event
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do
            b = pick_code();
        while (b == PFX_EXT1 || b == PFX_EXT2);
        return b;
    endfunction

    // Tail byte biased toward the pause release codes
    function automatic logic [7:0] pick_tail();
        case ($urandom_range(0, 3))
            0: return PFX_EXT2;
            1: return PAUSE_BREAK1;
            2: return PAUSE_BREAK2;
            default: return pick_code();
        endcase
    endfunction

    // Occasional new service call in the middle of a group
    function automatic logic stray_start();
        return $urandom_range(0, 39) == 0;
    endfunction

    // Offer one item and wait until the block takes it
    task automatic send_byte(input logic bs, input logic mouse, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0)
            tx_idle = !tx_idle;
        gap = tx_idle ? int'($urandom_range(0, 19)) : 0;
        if (gap > 0)
        begin
            in_valid    <= 1'b0;
            batch_start <= 1'($urandom_range(0, 1));
            from_mouse  <= 1'($urandom_range(0, 1));
            data_byte   <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        batch_start <= bs;
        from_mouse  <= mouse;
        data_byte   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predictor.note_byte(bs, mouse, b);
        items_sent++;
    endtask

    // Mostly well-formed key sequences with random content, some noise
    task automatic send_random_group();
        int   pick;
        int   n;
        logic bs;
        pick = int'($urandom_range(0, 99));
        bs   = ($urandom_range(0, 3) == 0);
        if (pick < 28)
            send_byte(bs, 1'b0, pick_plain());
        else if (pick < 42)
        begin
            send_byte(bs, 1'b0, PFX_EXT1);
            send_byte(stray_start(), 1'b0, pick_code());
        end
        else if (pick < 54)
        begin
            send_byte(bs, 1'b0, PFX_EXT1);
            send_byte(stray_start(), 1'b0, CODE_BREAK);
            send_byte(stray_start(), 1'b0, pick_code());
        end
        else if (pick < 62)
        begin
            send_byte(bs, 1'b0, PFX_EXT2);
            send_byte(stray_start(), 1'b0, pick_code());
            send_byte(stray_start(), 1'b0, pick_code());
        end
        else if (pick < 88)
        begin
            // pause make, then a release tail that is usually right
            send_byte(bs, 1'b0, PFX_EXT2);
            send_byte(stray_start(), 1'b0, PAUSE_MAKE1);
            send_byte(stray_start(), 1'b0, PAUSE_MAKE2);
            if (pick < 78)
            begin
                send_byte(stray_start(), 1'b0, PFX_EXT2);
                send_byte(stray_start(), 1'b0, PAUSE_BREAK1);
                send_byte(stray_start(), 1'b0, PAUSE_BREAK2);
            end
            else
            begin
                repeat (4) send_byte(stray_start(), 1'b0, pick_tail());
            end
        end
        else
        begin
            n = int'($urandom_range(1, 3));
            repeat (n)
                send_byte(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                          8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stall before each result, plus the long hold-off
    initial
    begin
        int hold_cycles;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_idle = !rx_idle;
            hold_cycles = rx_idle ? int'($urandom_range(0, 19)) : 0;
            do
            begin
                out_stall <= (hold_cycles > 0) || hold_off;
                @(posedge clk);
                if (hold_cycles > 0)
                    hold_cycles--;
            end
            while (!(out_valid && !out_stall));
            predictor.check_event(first_byte, second_byte, third_byte, prefix_kind);
        end
    end

    // Long receiver hold-off while the sender keeps offering items
    initial
    begin
        hold_off = 1'b0;
        wait (items_sent >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keyboard_scancode_assembler_unit regression: fail");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int i;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        batch_start = 1'b0;
        from_mouse  = 1'b0;
        data_byte   = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain byte on a new call, then the dropped bytes
        send_byte(1'b1, 1'b0, 8'h01);
        send_byte(1'b0, 1'b0, BYTE_NULL);
        send_byte(1'b0, 1'b0, BYTE_ACK);
        send_byte(1'b0, 1'b0, BYTE_RESEND);
        send_byte(1'b0, 1'b0, BYTE_ERROR);
        // mouse byte cuts an extended group short
        send_byte(1'b0, 1'b0, PFX_EXT1);
        send_byte(1'b0, 1'b1, PFX_EXT1);
        // extended make and break
        send_byte(1'b0, 1'b0, PFX_EXT1);
        send_byte(1'b0, 1'b0, 8'h75);
        send_byte(1'b0, 1'b0, PFX_EXT1);
        send_byte(1'b0, 1'b0, CODE_BREAK);
        send_byte(1'b0, 1'b0, 8'h7C);
        // full pause make and release
        send_byte(1'b0, 1'b0, PFX_EXT2);
        send_byte(1'b0, 1'b0, PAUSE_MAKE1);
        send_byte(1'b0, 1'b0, PAUSE_MAKE2);
        send_byte(1'b0, 1'b0, PFX_EXT2);
        send_byte(1'b0, 1'b0, PAUSE_BREAK1);
        send_byte(1'b0, 1'b0, PAUSE_BREAK2);
        // E1 with a second byte other than the pause make
        send_byte(1'b0, 1'b0, PFX_EXT2);
        send_byte(1'b0, 1'b0, 8'h14);
        send_byte(1'b0, 1'b0, 8'h77);
        // pause make with a wrong tail: one extra byte swallowed before the wrap
        send_byte(1'b0, 1'b0, PFX_EXT2);
        send_byte(1'b0, 1'b0, PAUSE_MAKE1);
        send_byte(1'b0, 1'b0, PAUSE_MAKE2);
        send_byte(1'b0, 1'b0, PFX_EXT2);
        send_byte(1'b0, 1'b0, PAUSE_BREAK1);
        send_byte(1'b0, 1'b0, 8'h33);
        send_byte(1'b0, 1'b0, 8'hFD);
        // new call in the middle of an extended group
        send_byte(1'b0, 1'b0, PFX_EXT1);
        send_byte(1'b1, 1'b0, 8'hFD);

        while (items_sent < RANDOM_ITEMS)
            send_random_group();
        in_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        for (i = 0; i < DRAIN_LIMIT && predictor.pending_events.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predictor.pending_events.size() != 0)
            predictor.report_mismatch($sformatf("%0d events never arrived",
                                                predictor.pending_events.size()));

        if (predictor.mismatches == 0)
            $display("keyboard_scancode_assembler_unit regression: pass");
        else
            $display("keyboard_scancode_assembler_unit regression: fail");
        $finish;
    end

endmodule
